[hdl/point_segment_distance_2d_macros.svh]
// Assertion macros for the point to segment distance block.
`ifndef POINT_SEGMENT_DISTANCE_2D_MACROS_SVH
`define POINT_SEGMENT_DISTANCE_2D_MACROS_SVH
`ifndef SYNTHESIS
`define PSD_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define PSD_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PSD_ASSERT_IMP(name, ante, cons, msg)
`define PSD_ASSERT_NXT(name, ante, cons, msg)
`endif
`endif

[hdl/psd_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the point to segment distance block.
package psd_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int DIST_W         = 25;

  typedef enum logic [1:0] {
    REG_START    = 2'd0,
    REG_INTERIOR = 2'd1,
    REG_END      = 2'd2,
    REG_DEGEN    = 2'd3
  } region_e;

  typedef struct packed {
    logic    vld;
    region_e region;
  } tag_t;

endpackage

[hdl/psd_front.sv]
`timescale 1ns / 1ps
// Geometry front end: differences, products, region choice and dividend setup.
module psd_front #(
  parameter int CB = 16,
  parameter int F  = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic signed [CB-1:0]   px_i,
  input  logic signed [CB-1:0]   py_i,
  input  logic signed [CB-1:0]   ax_i,
  input  logic signed [CB-1:0]   ay_i,
  input  logic signed [CB-1:0]   bx_i,
  input  logic signed [CB-1:0]   by_i,
  output psd_pkg::tag_t          tag_o,
  output logic [2*CB:0]          rem_o,
  output logic [2*(CB+1+F)-1:0]  quo_o,
  output logic [2*CB:0]          div_o
);
  import psd_pkg::*;

  localparam int DW = 2*CB+1;
  localparam int QW = 2*(CB+1+F);
  localparam int PW = 2*CB+2;
  localparam int H  = CB+1;
  localparam int NW = 4*CB+2+2*F;

  // Stage 1: coordinate differences.
  logic              s1_vld_q;
  logic signed [CB:0] dx_q, dy_q, ux_q, uy_q, ex_q, ey_q;
  // Stage 2: products.
  logic              s2_vld_q;
  logic signed [PW-1:0] ddx_q, ddy_q, dtx_q, dty_q, cra_q, crb_q;
  logic signed [PW-1:0] uux_q, uuy_q, eex_q, eey_q;
  // Stage 3: sums.
  logic              s3_vld_q;
  logic [DW-1:0]     dd3_q, su3_q, se3_q;
  logic signed [PW:0] dot3_q, cr3_q;
  logic [PW-1:0]     dd_w, su_w, se_w;
  // Stage 4: region and magnitudes.
  tag_t              s4_tag_q;
  region_e           region_w;
  logic signed [PW:0] crneg_w, crabs_w;
  logic [DW-1:0]     c4_q, s4_q, dd4_q;
  // Stage 5: partial products of the cross term square.
  tag_t              s5_tag_q;
  logic [2*H-1:0]    cpad_w;
  logic [2*H-1:0]    hh5_q, hl5_q, ll5_q;
  logic [DW-1:0]     s5_q, dd5_q;
  // Stage 6: dividend split into the initial remainder and low bits.
  tag_t              s6_tag_q;
  logic [NW-1:0]     c2_w, n_w;
  logic [DW-1:0]     rem6_q, div6_q;
  logic [QW-1:0]     quo6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_tag_q <= '0;
      s5_tag_q <= '0;
      s6_tag_q <= '0;
    end else if (en_i) begin
      s1_vld_q <= valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_tag_q <= '{vld: s3_vld_q, region: region_w};
      s5_tag_q <= s4_tag_q;
      s6_tag_q <= s5_tag_q;
    end
  end

  always_comb begin
    dd_w = ddx_q + ddy_q;
    su_w = uux_q + uuy_q;
    se_w = eex_q + eey_q;
  end

  always_comb begin
    if (dd3_q == '0) begin
      region_w = REG_DEGEN;
    end else if (dot3_q <= 0) begin
      region_w = REG_START;
    end else if (dot3_q[PW-1:0] >= {1'b0, dd3_q}) begin
      region_w = REG_END;
    end else begin
      region_w = REG_INTERIOR;
    end
    crneg_w = -cr3_q;
    crabs_w = cr3_q[PW] ? crneg_w : cr3_q;
  end

  assign cpad_w = {{(2*H-DW){1'b0}}, c4_q};

  always_comb begin
    c2_w = (NW'(hh5_q) << (2*H)) + (NW'(hl5_q) << (H+1)) + NW'(ll5_q);
    if (s5_tag_q.region == REG_INTERIOR) begin
      n_w = c2_w << (2*F);
    end else begin
      n_w = NW'(s5_q) << (2*F);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q <= {bx_i[CB-1], bx_i} - {ax_i[CB-1], ax_i};
      dy_q <= {by_i[CB-1], by_i} - {ay_i[CB-1], ay_i};
      ux_q <= {px_i[CB-1], px_i} - {ax_i[CB-1], ax_i};
      uy_q <= {py_i[CB-1], py_i} - {ay_i[CB-1], ay_i};
      ex_q <= {px_i[CB-1], px_i} - {bx_i[CB-1], bx_i};
      ey_q <= {py_i[CB-1], py_i} - {by_i[CB-1], by_i};

      ddx_q <= dx_q * dx_q;
      ddy_q <= dy_q * dy_q;
      dtx_q <= ux_q * dx_q;
      dty_q <= uy_q * dy_q;
      cra_q <= ux_q * dy_q;
      crb_q <= uy_q * dx_q;
      uux_q <= ux_q * ux_q;
      uuy_q <= uy_q * uy_q;
      eex_q <= ex_q * ex_q;
      eey_q <= ey_q * ey_q;

      dd3_q  <= dd_w[DW-1:0];
      su3_q  <= su_w[DW-1:0];
      se3_q  <= se_w[DW-1:0];
      dot3_q <= dtx_q + dty_q;
      cr3_q  <= cra_q - crb_q;

      c4_q  <= crabs_w[DW-1:0];
      s4_q  <= (region_w == REG_END) ? se3_q : su3_q;
      dd4_q <= dd3_q;

      hh5_q <= cpad_w[2*H-1:H] * cpad_w[2*H-1:H];
      hl5_q <= cpad_w[2*H-1:H] * cpad_w[H-1:0];
      ll5_q <= cpad_w[H-1:0] * cpad_w[H-1:0];
      s5_q  <= s4_q;
      dd5_q <= dd4_q;

      rem6_q <= {{(DW-(NW-QW)){1'b0}}, n_w[NW-1:QW]};
      quo6_q <= n_w[QW-1:0];
      div6_q <= (s5_tag_q.region == REG_INTERIOR) ? dd5_q : DW'(1);
    end
  end

  assign tag_o = s6_tag_q;
  assign rem_o = rem6_q;
  assign quo_o = quo6_q;
  assign div_o = div6_q;

endmodule

[hdl/psd_div_cell.sv]
`timescale 1ns / 1ps
// One restoring division cell: develops one quotient bit per item.
module psd_div_cell #(
  parameter int DW = 33,
  parameter int QW = 50
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  psd_pkg::tag_t tag_i,
  input  logic [DW-1:0] rem_i,
  input  logic [DW-1:0] div_i,
  input  logic [QW-1:0] quo_i,
  output psd_pkg::tag_t tag_o,
  output logic [DW-1:0] rem_o,
  output logic [DW-1:0] div_o,
  output logic [QW-1:0] quo_o
);
  import psd_pkg::*;

  tag_t          tag_q;
  logic [DW-1:0] rem_q, div_q;
  logic [QW-1:0] quo_q;
  logic [DW:0]   cand_w, diff_w;
  logic          ge_w;

  // The word shifts left: a dividend bit leaves at the top, a quotient bit enters below.
  always_comb begin
    cand_w = {rem_i, quo_i[QW-1]};
    diff_w = cand_w - {1'b0, div_i};
    ge_w   = cand_w >= {1'b0, div_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else if (en_i) begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= ge_w ? diff_w[DW-1:0] : cand_w[DW-1:0];
      div_q <= div_i;
      quo_q <= {quo_i[QW-2:0], ge_w};
    end
  end

  assign tag_o = tag_q;
  assign rem_o = rem_q;
  assign div_o = div_q;
  assign quo_o = quo_q;

endmodule

[hdl/psd_sqrt_cell.sv]
`timescale 1ns / 1ps
// One digit-by-digit square root cell: develops one root bit per item.
module psd_sqrt_cell #(
  parameter int RW = 25,
  parameter int QW = 50
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  psd_pkg::tag_t tag_i,
  input  logic [RW+1:0] rem_i,
  input  logic [RW-1:0] root_i,
  input  logic [QW-1:0] val_i,
  output psd_pkg::tag_t tag_o,
  output logic [RW+1:0] rem_o,
  output logic [RW-1:0] root_o,
  output logic [QW-1:0] val_o
);
  import psd_pkg::*;

  tag_t          tag_q;
  logic [RW+1:0] rem_q;
  logic [RW-1:0] root_q;
  logic [QW-1:0] val_q;
  logic [RW+3:0] cand_w, trial_w, diff_w;
  logic          ge_w;

  // Two radicand bits enter per step; the trial subtrahend is 4*root + 1.
  always_comb begin
    cand_w  = {rem_i, val_i[QW-1:QW-2]};
    trial_w = {2'b00, root_i, 2'b01};
    diff_w  = cand_w - trial_w;
    ge_w    = cand_w >= trial_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else if (en_i) begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= ge_w ? diff_w[RW+1:0] : cand_w[RW+1:0];
      root_q <= {root_i[RW-2:0], ge_w};
      val_q  <= val_i << 2;
    end
  end

  assign tag_o  = tag_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign val_o  = val_q;

endmodule

[hdl/point_segment_distance_2d.sv]
`timescale 1ns / 1ps
// Usage: an input item carries a query point (px, py) and a segment from
// (ax, ay) to (bx, by); the result item gives the distance from the point to
// the segment in fixed point with FRAC_BITS fraction bits, truncated, and the
// region of the segment that was nearest.
// Both channels use valid and stall; an item moves on an edge with valid high
// and stall low. One item is accepted per cycle as long as results drain.
// An item passes through six geometry stages, a row of division cells with
// one quotient bit each, a row of square root cells with one root bit each,
// and the output register. Throughput is one item per cycle while results
// drain.
// When the receiver stalls a waiting result, the cell rows keep moving until
// an item reaches the last cell, then the whole row holds and input stalls.
// Reset clears all valid bits; no result is presented after reset.
module point_segment_distance_2d #(
  parameter int COORD_BITS = psd_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = psd_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_BITS-1:0]  px_i,
  input  logic signed [COORD_BITS-1:0]  py_i,
  input  logic signed [COORD_BITS-1:0]  ax_i,
  input  logic signed [COORD_BITS-1:0]  ay_i,
  input  logic signed [COORD_BITS-1:0]  bx_i,
  input  logic signed [COORD_BITS-1:0]  by_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [psd_pkg::DIST_W-1:0]    distance_o,
  output logic [1:0]                    nearest_region_o
);
  import psd_pkg::*;

  `include "point_segment_distance_2d_macros.svh"

  localparam int DW = 2*COORD_BITS+1;
  localparam int RW = COORD_BITS+1+FRAC_BITS;
  localparam int QW = 2*RW;

  tag_t          div_tag  [QW+1];
  logic [DW-1:0] div_rem  [QW+1];
  logic [DW-1:0] div_div  [QW+1];
  logic [QW-1:0] div_quo  [QW+1];
  tag_t          sq_tag   [RW+1];
  logic [RW+1:0] sq_rem   [RW+1];
  logic [RW-1:0] sq_root  [RW+1];
  logic [QW-1:0] sq_val   [RW+1];

  logic              load_w, en_w;
  logic              vld_q;
  logic [DIST_W-1:0] dist_q, dist_w;
  region_e           region_q;

  // The output register loads when empty or taken; the rows may also move
  // while their last cell is empty.
  assign load_w     = !vld_q || !out_stall_i;
  assign en_w       = load_w || !sq_tag[RW].vld;
  assign in_stall_o = !en_w;

  psd_front #(.CB(COORD_BITS), .F(FRAC_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_w),
    .valid_i (in_valid_i),
    .px_i    (px_i),
    .py_i    (py_i),
    .ax_i    (ax_i),
    .ay_i    (ay_i),
    .bx_i    (bx_i),
    .by_i    (by_i),
    .tag_o   (div_tag[0]),
    .rem_o   (div_rem[0]),
    .quo_o   (div_quo[0]),
    .div_o   (div_div[0])
  );

  for (genvar i = 0; i < QW; i++) begin : g_div
    psd_div_cell #(.DW(DW), .QW(QW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_w),
      .tag_i  (div_tag[i]),
      .rem_i  (div_rem[i]),
      .div_i  (div_div[i]),
      .quo_i  (div_quo[i]),
      .tag_o  (div_tag[i+1]),
      .rem_o  (div_rem[i+1]),
      .div_o  (div_div[i+1]),
      .quo_o  (div_quo[i+1])
    );
  end

  assign sq_tag[0]  = div_tag[QW];
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_val[0]  = div_quo[QW];

  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    psd_sqrt_cell #(.RW(RW), .QW(QW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_w),
      .tag_i  (sq_tag[j]),
      .rem_i  (sq_rem[j]),
      .root_i (sq_root[j]),
      .val_i  (sq_val[j]),
      .tag_o  (sq_tag[j+1]),
      .rem_o  (sq_rem[j+1]),
      .root_o (sq_root[j+1]),
      .val_o  (sq_val[j+1])
    );
  end

  if (RW > DIST_W) begin : g_sat
    assign dist_w = (|sq_root[RW][RW-1:DIST_W]) ? '1 : sq_root[RW][DIST_W-1:0];
  end else if (RW == DIST_W) begin : g_fit
    assign dist_w = sq_root[RW];
  end else begin : g_ext
    assign dist_w = {{(DIST_W-RW){1'b0}}, sq_root[RW]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load_w) begin
      vld_q <= sq_tag[RW].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_w) begin
      dist_q   <= dist_w;
      region_q <= sq_tag[RW].region;
    end
  end

  assign out_valid_o      = vld_q;
  assign distance_o       = dist_q;
  assign nearest_region_o = region_q;

  `PSD_ASSERT_IMP(a_div_divisor_one, div_tag[0].vld && div_tag[0].region != REG_INTERIOR, div_div[0] == DW'(1), "end point item entered the divider with a divisor other than one")
  `PSD_ASSERT_IMP(a_div_rem_below, div_tag[QW].vld, div_rem[QW] < div_div[QW], "final division remainder is not below the divisor")
  `PSD_ASSERT_IMP(a_sqrt_rem_bound, sq_tag[RW].vld, sq_rem[RW] <= ((RW+2)'(sq_root[RW]) << 1), "square root remainder exceeds twice the root")
  `PSD_ASSERT_NXT(a_last_cell_holds, sq_tag[RW].vld && !en_w, sq_tag[RW].vld, "item in the last cell was lost while the row was held")

endmodule
